// ----- hw/rtl/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants, codes and controller/datapath interface types for the
// LZW dictionary table.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  // fixed field widths
  localparam int FUNC_W = 2;
  localparam int CODE_W = 6;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_NEW = 2'd0;
  localparam logic [FUNC_W-1:0] FN_EXT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SET = 2'd2;
  localparam logic [FUNC_W-1:0] FN_GET = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDEF = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              latch;        // capture the input item
    logic              commit;       // write new/extend entry, bump next code
    logic              set_sfx;      // overwrite suffix of code
    logic              walk_start;   // clear length, read entry at code
    logic              walk_step;    // push suffix, follow prefix
    logic              pop_emit;     // output one stacked byte
    logic              emit_single;  // output a one-item result
    logic              emit_code;    // single result carries assigned code
    logic [STAT_W-1:0] emit_status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              defined;
    logic              walk_end;
    logic              pop_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/lzw_dictionary_table.sv -----
// ----------------------------------------------------------------------------
// lzw_dictionary_table
// LZW code dictionary: new root, extend, set suffix and get string, with a
// sequencer driving the dictionary datapath.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   command  | start / busy         | func, code_in, byte_val
//   result   | result_valid strobe  | status, new_code, data_byte,
//            |                      | string_length, last
//
// Sequence: new, extend and set suffix pass through capture and decode; the
//   result strobes in the cycle after decode, while busy is already low.
// Get captures, decodes and walks, then reads the stack and gives N results,
//   one byte per cycle, for a string of N bytes; the walk follows one prefix
//   link per cycle through the registered read port of the entry RAM.
// Reset clears the next-code counter, result strobe and control state only;
//   entries are read only below the next code, so the RAMs need no clearing.
// The result side has no back-pressure: every result shows for one cycle.
//
module lzw_dictionary_table import lzwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // command side
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [CODE_W-1:0] code_in,
  input  logic [BYTE_W-1:0] byte_val,
  // result side
  output logic              result_valid,
  output logic [STAT_W-1:0] status,
  output logic [CODE_W-1:0] new_code,
  output logic [BYTE_W-1:0] data_byte,
  output logic [LEN_W-1:0]  string_length,
  output logic              last
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: decode and walk/pop sequencing
  lzwd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // storage, counters and result registers
  lzwd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .func          (func),
    .code_in       (code_in),
    .byte_val      (byte_val),
    .result_valid  (result_valid),
    .status        (status),
    .new_code      (new_code),
    .data_byte     (data_byte),
    .string_length (string_length),
    .last          (last)
  );

  // error results are always single items
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> last)
    else $error("error result not marked last");

  // a get string streams without gaps until its last byte
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("gap in get string output");

  // error results carry no code and no length
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> (new_code == '0 && string_length == '0))
    else $error("error result with payload");

  // an accepted item always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

// ----- hw/rtl/lzwd_ram.sv -----
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/lzwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer: decode, prefix-chain walk, and forward byte output.
// ----------------------------------------------------------------------------
module lzwd_ctrl import lzwd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        case (stat.func)
          FN_NEW, FN_EXT: begin
            cmd.emit_single = 1'b1;
            if (stat.full) begin
              cmd.emit_status = ST_FULL;
            end else if (stat.func == FN_EXT && !stat.defined) begin
              cmd.emit_status = ST_UNDEF;
            end else begin
              cmd.emit_status = ST_OK;
              cmd.emit_code   = 1'b1;
              cmd.commit      = 1'b1;
            end
          end
          FN_SET: begin
            cmd.emit_single = 1'b1;
            if (!stat.defined) begin
              cmd.emit_status = ST_UNDEF;
            end else begin
              cmd.emit_status = ST_OK;
              cmd.set_sfx     = 1'b1;
            end
          end
          default: begin
            if (!stat.defined) begin
              cmd.emit_single = 1'b1;
              cmd.emit_status = ST_UNDEF;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_end) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.pop_emit = 1'b1;
        if (stat.pop_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a walk is entered only from decode and then stays in walk until it ends
  a_walk_from_decode: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ($past(state) == S_DECODE || $past(state) == S_WALK))
    else $error("walk entered out of sequence");

  // stacked output starts only after the walk has ended
  a_pop_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(state) == S_WALK && $past(stat.walk_end)))
    else $error("pop without finished walk");

  // only one kind of result per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pop_emit && cmd.emit_single))
    else $error("two results issued at once");

endmodule

// ----- hw/rtl/lzwd_datapath.sv -----
// ----------------------------------------------------------------------------
// lzwd_datapath
// Dictionary RAMs, next-code counter, reverse stack and result registers.
// ----------------------------------------------------------------------------
module lzwd_datapath import lzwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic [FUNC_W-1:0] func,
  input  logic [CODE_W-1:0] code_in,
  input  logic [BYTE_W-1:0] byte_val,
  output logic              result_valid,
  output logic [STAT_W-1:0] status,
  output logic [CODE_W-1:0] new_code,
  output logic [BYTE_W-1:0] data_byte,
  output logic [LEN_W-1:0]  string_length,
  output logic              last
);

  // captured item
  logic [FUNC_W-1:0] func_q;
  logic [CODE_W-1:0] code_q;
  logic [BYTE_W-1:0] byte_q;

  logic [CNT_W-1:0]  next_code;
  logic [CNT_W-1:0]  len;
  logic [ADDR_W-1:0] ptr;

  logic [ADDR_W-1:0] code_idx;
  logic [ADDR_W-1:0] new_idx;
  logic [CNT_W-1:0]  len_inc;

  // entry RAM holds {root, prefix}
  logic              ent_we;
  logic [ADDR_W:0]   ent_wdata;
  logic [ADDR_W-1:0] ent_raddr;
  logic [ADDR_W:0]   ent_rdata;
  logic              sfx_we;
  logic [ADDR_W-1:0] sfx_waddr;
  logic [BYTE_W-1:0] sfx_wdata;
  logic [BYTE_W-1:0] sfx_rdata;
  logic [ADDR_W-1:0] stk_raddr;
  logic [BYTE_W-1:0] stk_rdata;

  assign code_idx = code_q[ADDR_W-1:0];
  assign new_idx  = next_code[ADDR_W-1:0];
  assign len_inc  = len + CNT_W'(1);

  assign stat.func     = func_q;
  assign stat.full     = (next_code >= CNT_W'(TABLE_DEPTH));
  assign stat.defined  = (LEN_W'(code_q) < LEN_W'(next_code));
  assign stat.walk_end = ent_rdata[ADDR_W] || (len_inc == CNT_W'(TABLE_DEPTH));
  assign stat.pop_last = (ptr == '0);

  assign ent_we    = cmd.commit;
  assign ent_wdata = (func_q == FN_NEW) ? {1'b1, {ADDR_W{1'b0}}} : {1'b0, code_idx};
  assign ent_raddr = cmd.walk_step ? ent_rdata[ADDR_W-1:0] : code_idx;

  assign sfx_we    = cmd.commit || cmd.set_sfx;
  assign sfx_waddr = cmd.commit ? new_idx : code_idx;
  assign sfx_wdata = (cmd.commit && func_q != FN_NEW) ? '0 : byte_q;

  assign stk_raddr = cmd.pop_emit ? ptr - ADDR_W'(1) : ptr;

  lzwd_ram #(.WIDTH(ADDR_W + 1), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (new_idx),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  lzwd_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_suffix_ram (
    .clk   (clk),
    .we    (sfx_we),
    .waddr (sfx_waddr),
    .wdata (sfx_wdata),
    .raddr (ent_raddr),
    .rdata (sfx_rdata)
  );

  lzwd_ram #(.WIDTH(BYTE_W), .DEPTH(TABLE_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.walk_step),
    .waddr (len[ADDR_W-1:0]),
    .wdata (sfx_rdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      next_code    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        next_code <= next_code + CNT_W'(1);
      end
      result_valid <= cmd.emit_single || cmd.pop_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func;
      code_q <= code_in;
      byte_q <= byte_val;
    end
    if (cmd.walk_start) begin
      len <= '0;
    end else if (cmd.walk_step) begin
      len <= len_inc;
      ptr <= len[ADDR_W-1:0];
    end else if (cmd.pop_emit) begin
      ptr <= ptr - ADDR_W'(1);
    end
    if (cmd.emit_single) begin
      status        <= cmd.emit_status;
      new_code      <= cmd.emit_code ? CODE_W'(next_code) : '0;
      data_byte     <= '0;
      string_length <= '0;
      last          <= 1'b1;
    end else if (cmd.pop_emit) begin
      status        <= ST_OK;
      new_code      <= '0;
      data_byte     <= stk_rdata;
      string_length <= LEN_W'(len);
      last          <= (ptr == '0);
    end
  end

endmodule

// ----- tb/lzwd_check_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwd_check_pkg
// Dictionary shadow for the LZW dictionary table testbench: keeps its own
// copy of the entries, works out the result items of every accepted command
// item and compares the block's result items against them in order.
// ----------------------------------------------------------------------------
package lzwd_check_pkg;
  import lzwd_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CODE_W-1:0] new_code;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  string_length;
    logic              last;
  } dict_result_t;

  class lzw_dict_shadow;
    logic [CODE_W-1:0] prefix_of [TABLE_DEPTH];
    logic [BYTE_W-1:0] suffix_of [TABLE_DEPTH];
    bit                is_root   [TABLE_DEPTH];
    int unsigned       next_free;
    dict_result_t      awaited[$];
    int unsigned       mismatches;

    function new();
      next_free  = 0;
      mismatches = 0;
    endfunction

    function void push_single(logic [STAT_W-1:0] st, logic [CODE_W-1:0] code);
      awaited.push_back('{st, code, '0, '0, 1'b1});
    endfunction

    // Called once per accepted command item.
    function void note_command(logic [FUNC_W-1:0] fn, logic [CODE_W-1:0] code,
                               logic [BYTE_W-1:0] bval);
      logic [BYTE_W-1:0] walked[$];
      int unsigned       cur;
      int unsigned       len;
      bit                known;
      bit                at_root;
      known = code < next_free;
      case (fn)
        FN_NEW, FN_EXT: begin
          // full wins over an undefined prefix
          if (next_free >= TABLE_DEPTH) begin
            push_single(ST_FULL, '0);
          end else if (fn == FN_EXT && !known) begin
            push_single(ST_UNDEF, '0);
          end else begin
            suffix_of[next_free] = (fn == FN_NEW) ? bval : '0;
            prefix_of[next_free] = (fn == FN_NEW) ? '0 : code;
            is_root[next_free]   = (fn == FN_NEW);
            push_single(ST_OK, CODE_W'(next_free));
            next_free++;
          end
        end
        FN_SET: begin
          if (!known) begin
            push_single(ST_UNDEF, '0);
          end else begin
            suffix_of[code] = bval;
            push_single(ST_OK, '0);
          end
        end
        default: begin
          if (!known) begin
            push_single(ST_UNDEF, '0);
          end else begin
            // backward walk to the root, then emit first byte first
            cur     = code;
            at_root = 1'b0;
            while (!at_root && walked.size() < TABLE_DEPTH) begin
              walked.push_back(suffix_of[cur]);
              at_root = is_root[cur];
              cur     = prefix_of[cur];
            end
            len = walked.size();
            for (int k = len - 1; k >= 0; k--)
              awaited.push_back('{ST_OK, '0, walked[k], LEN_W'(len), k == 0});
          end
        end
      endcase
    endfunction

    function void report(string what, dict_result_t exp, dict_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected st=%0d code=%0d byte=%02h len=%0d last=%0b, got st=%0d code=%0d byte=%02h len=%0d last=%0b",
                 what, exp.status, exp.new_code, exp.data_byte, exp.string_length,
                 exp.last, got.status, got.new_code, got.data_byte,
                 got.string_length, got.last);
    endfunction

    // Called once per result strobe.
    function void check_result(dict_result_t got);
      dict_result_t exp;
      if (awaited.size() == 0) begin
        report("unexpected result", '0, got);
      end else begin
        exp = awaited.pop_front();
        if (got.status !== exp.status || got.new_code !== exp.new_code ||
            got.data_byte !== exp.data_byte ||
            got.string_length !== exp.string_length || got.last !== exp.last)
          report("result mismatch", exp, got);
      end
    endfunction
  endclass

endpackage

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lzw_dictionary_table: directed corner items, a
// random mix of new/extend/set/get items that grows chains and fills the
// table, and a closing phase at the full table, all checked per result item.
// ----------------------------------------------------------------------------
module testbench;
  import lzwd_pkg::*;
  import lzwd_check_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 150;
  localparam int BATCH        = 25;
  localparam int SETTLE       = 32;   // quiet cycles after the last result

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [FUNC_W-1:0] func = FN_NEW;
  logic [CODE_W-1:0] code_in = '0;
  logic [BYTE_W-1:0] byte_val = '0;
  logic              busy;
  logic              result_valid;
  logic [STAT_W-1:0] status;
  logic [CODE_W-1:0] new_code;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  string_length;
  logic              last;

  lzw_dict_shadow shadow;
  int unsigned    cycles = 0;
  // driver-side count of codes handed out, so stimulus shaping never depends
  // on when the monitor has run within a time step
  int unsigned    codes_made = 0;
  bit             no_idle = 1'b0;

  lzw_dictionary_table DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .code_in       (code_in),
    .byte_val      (byte_val),
    .result_valid  (result_valid),
    .status        (status),
    .new_code      (new_code),
    .data_byte     (data_byte),
    .string_length (string_length),
    .last          (last)
  );

  always #6 clk = ~clk;

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: all reads are of pre-edge values. Results are checked before the
  // command of the same edge is noted, so a stray result never meets the
  // expectation of an item accepted at that very edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid === 1'b1)
        shadow.check_result('{status, new_code, data_byte, string_length, last});
      if (start === 1'b1 && busy === 1'b0)
        shadow.note_command(func, code_in, byte_val);
    end
  end

  // One command item: random idle gap (none in burst stretches), then hold
  // start until the edge where busy is low. Returns at the accepting edge, so
  // back-to-back items keep start high with a single update per step.
  task automatic send_command(input logic [FUNC_W-1:0] fn,
                              input logic [CODE_W-1:0] code,
                              input logic [BYTE_W-1:0] bval);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    func     <= fn;
    code_in  <= code;
    byte_val <= bval;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (codes_made < TABLE_DEPTH &&
        (fn == FN_NEW || (fn == FN_EXT && code < codes_made)))
      codes_made++;
  endtask

  // Stop sending until every expected result item has come back. Always lets
  // at least one edge pass so start is never lowered and raised in one step.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.awaited.size() != 0) @(posedge clk);
  endtask

  // Random item: mostly well-formed (codes that exist, extends that deepen
  // the newest chain), the rest random codes that may be undefined.
  task automatic send_random();
    int unsigned       roll;
    logic [FUNC_W-1:0] fn;
    logic [CODE_W-1:0] code;
    roll = $urandom_range(0, 99);
    if (roll < 15)      fn = FN_NEW;
    else if (roll < 35) fn = FN_EXT;
    else if (roll < 55) fn = FN_SET;
    else                fn = FN_GET;
    if (codes_made != 0 && $urandom_range(0, 9) < 8) begin
      if (fn == FN_EXT && $urandom_range(0, 1) == 1)
        code = CODE_W'(codes_made - 1);
      else
        code = CODE_W'($urandom_range(0, codes_made - 1));
    end else begin
      code = CODE_W'($urandom_range(0, 63));
    end
    send_command(fn, code, BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    shadow = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty table, byte extremes, chain walk, undefined codes
    send_command(FN_GET, 6'd0,  8'h00);   // nothing defined yet
    send_command(FN_EXT, 6'd0,  8'hFF);
    send_command(FN_SET, 6'd0,  8'hFF);
    send_command(FN_NEW, 6'd63, 8'h00);   // code 0, code_in ignored
    send_command(FN_NEW, 6'd0,  8'hFF);   // code 1
    send_command(FN_GET, 6'd0,  8'h00);   // single byte string
    send_command(FN_EXT, 6'd1,  8'h00);   // code 2 -> 1
    send_command(FN_EXT, 6'd2,  8'h00);   // code 3 -> 2 -> 1
    send_command(FN_GET, 6'd3,  8'h00);   // suffixes of extends start at 0
    send_command(FN_SET, 6'd3,  8'hA5);
    send_command(FN_SET, 6'd1,  8'h5A);   // change a root inside the chain
    send_command(FN_GET, 6'd3,  8'h00);
    send_command(FN_EXT, 6'd0,  8'h00);   // code 4 on a root byte of 0
    send_command(FN_GET, 6'd4,  8'h00);
    send_command(FN_GET, 6'd5,  8'h00);   // first code not yet handed out
    send_command(FN_EXT, 6'd63, 8'h00);
    send_command(FN_SET, 6'd63, 8'h00);
    send_command(FN_GET, 6'd63, 8'hFF);

    // --- random mix, idle and burst stretches per batch
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BATCH == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2)
        wait_drained();
      send_random();
    end
    no_idle = 1'b0;
    wait_drained();

    // --- closing: fill the table by deepening one chain, then full cases
    while (codes_made < TABLE_DEPTH)
      send_command(FN_EXT, CODE_W'(codes_made - 1), BYTE_W'($urandom_range(0, 255)));
    send_command(FN_NEW, 6'd0,  8'hFF);   // table full
    send_command(FN_EXT, 6'd63, 8'h00);   // full is checked before the prefix
    send_command(FN_GET, 6'd63, 8'h00);   // top code, long walk
    send_command(FN_SET, 6'd63, 8'hFF);
    send_command(FN_GET, 6'd63, 8'h00);
    for (int n = 0; n < 20; n++)
      send_random();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.awaited.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
